/* hw/rtl/kps_pkg.sv */
// Shared types, constants and marker tables for the particle selector.
// No dependencies; used by kps_rewrite and korean_particle_selector.
`timescale 1ns / 1ps

package kps_pkg;

  localparam int CodePointBits = 21;
  localparam int OutBits       = 21;
  localparam int OutDataBits   = 24;
  localparam int MaxResults    = 4;
  localparam int MarkerCount   = 8;
  localparam int FinalCount    = 28;

  localparam logic [15:0] OpenParen   = 16'h0028;
  localparam logic [15:0] CloseParen  = 16'h0029;
  localparam logic [15:0] HangulFirst = 16'hAC00;
  localparam logic [15:0] HangulLast  = 16'hD7A3;
  localparam logic [4:0]  FinalRieul  = 5'd8;
  // floor(2^16 / 28); quotient estimate is at most one low
  localparam logic [11:0] Reciprocal  = 12'd2340;

  localparam logic [0:MarkerCount-1][15:0] MarkerInner = '{
    16'hC774, 16'hC640, 16'hC744, 16'hC740, 16'hC544, 16'hC73C, 16'hC774, 16'hC774};
  localparam logic [0:MarkerCount-1][15:0] MarkerTail = '{
    16'hAC00, 16'hACFC, 16'hB97C, 16'hB294, 16'hC57C, 16'hB85C, 16'hC5EC, 16'hB77C};
  localparam logic [0:MarkerCount-1][15:0] MarkerWith0 = '{
    16'hC774, 16'hACFC, 16'hC744, 16'hC740, 16'hC544, 16'hC73C, 16'hC774, 16'hC774};
  localparam logic [0:MarkerCount-1][15:0] MarkerWith1 = '{
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hB85C, 16'hC5EC, 16'hB77C};
  localparam logic [0:MarkerCount-1][15:0] MarkerNo0 = '{
    16'hAC00, 16'hC640, 16'hB97C, 16'hB294, 16'hC57C, 16'hB85C, 16'hC5EC, 16'hB77C};
  localparam logic [0:MarkerCount-1] MarkerEulRo = 8'b00000100;

  typedef struct packed {
    logic [1:0]  count;
    logic [15:0] inner;
    logic [4:0]  inner_fc;
    logic        prior_valid;
    logic [4:0]  prior_fc;
  } kps_state_t;

  typedef struct packed {
    logic [2:0]                           count;
    logic [MaxResults-1:0][OutBits-1:0]   cp;
  } kps_burst_t;

  // final-consonant index of a Hangul syllable, zero for anything else
  function automatic logic [4:0] hangul_final(input logic [31:0] cp);
    logic [13:0] off;
    logic [25:0] prod;
    logic [13:0] quo;
    logic [13:0] rem;
    if (cp < 32'(HangulFirst) || cp > 32'(HangulLast)) begin
      return 5'd0;
    end
    off  = 14'(cp[15:0] - HangulFirst);
    prod = 26'(off) * 26'(Reciprocal);
    quo  = 14'(prod[25:16]);
    rem  = off - 14'(quo * 14'(FinalCount));
    if (rem >= 14'(FinalCount)) begin
      rem = rem - 14'(FinalCount);
    end
    return rem[4:0];
  endfunction

endpackage

/* hw/rtl/kps_rewrite.sv */
// Marker matching and particle choice for one code point.
// Combinational; depends on kps_pkg for tables, state and burst types.
`timescale 1ns / 1ps

module kps_rewrite #(
  parameter int CpBits = kps_pkg::CodePointBits
) (
  input  logic [CpBits-1:0]       cp_i,
  input  logic                    eot_i,
  input  kps_pkg::kps_state_t     state_i,
  output kps_pkg::kps_state_t     state_o,
  output kps_pkg::kps_burst_t     burst_o
);

  logic [31:0] c32;
  logic [15:0] c16;
  logic        c_narrow;
  logic [4:0]  c_fc;
  logic        c_inner;
  logic        hit;
  logic [2:0]  hit_idx;

  assign c32      = 32'(cp_i);
  assign c16      = c32[15:0];
  assign c_narrow = (c32[31:16] == 16'd0);
  assign c_fc     = kps_pkg::hangul_final(c32);

  always_comb begin
    c_inner = 1'b0;
    hit     = 1'b0;
    hit_idx = 3'd0;
    for (int i = 0; i < kps_pkg::MarkerCount; i++) begin
      if (c_narrow && c16 == kps_pkg::MarkerInner[i]) begin
        c_inner = 1'b1;
      end
      if (c_narrow && c16 == kps_pkg::MarkerTail[i] &&
          state_i.inner == kps_pkg::MarkerInner[i]) begin
        hit     = 1'b1;
        hit_idx = 3'(i);
      end
    end
  end

  always_comb begin
    logic [2:0] n;
    logic       plain;
    logic       batchim;
    logic [1:0] held;
    state_o = state_i;
    burst_o = '0;
    n       = 3'd0;
    plain   = 1'b0;
    held    = state_i.count;
    batchim = (state_i.prior_fc != 5'd0) &&
              !(kps_pkg::MarkerEulRo[hit_idx] && state_i.prior_fc == kps_pkg::FinalRieul);
    case (state_i.count)
      2'd0: begin
        plain = 1'b1;
      end
      2'd1: begin
        if (c_inner) begin
          state_o.count    = 2'd2;
          state_o.inner    = c16;
          state_o.inner_fc = c_fc;
        end else begin
          burst_o.cp[n[1:0]] = kps_pkg::OutBits'(kps_pkg::OpenParen);
          n = n + 3'd1;
          state_o.prior_fc    = 5'd0;
          state_o.prior_valid = 1'b1;
          state_o.count       = 2'd0;
          plain = 1'b1;
        end
      end
      2'd2: begin
        if (c_narrow && c16 == kps_pkg::CloseParen) begin
          state_o.count = 2'd3;
        end else begin
          burst_o.cp[n[1:0]] = kps_pkg::OutBits'(kps_pkg::OpenParen);
          n = n + 3'd1;
          burst_o.cp[n[1:0]] = kps_pkg::OutBits'(state_i.inner);
          n = n + 3'd1;
          state_o.prior_fc    = state_i.inner_fc;
          state_o.prior_valid = 1'b1;
          state_o.count       = 2'd0;
          plain = 1'b1;
        end
      end
      default: begin
        state_o.count = 2'd0;
        if (!hit || !state_i.prior_valid) begin
          burst_o.cp[n[1:0]] = kps_pkg::OutBits'(kps_pkg::OpenParen);
          n = n + 3'd1;
          burst_o.cp[n[1:0]] = kps_pkg::OutBits'(state_i.inner);
          n = n + 3'd1;
          burst_o.cp[n[1:0]] = kps_pkg::OutBits'(kps_pkg::CloseParen);
          n = n + 3'd1;
          state_o.prior_fc    = 5'd0;
          state_o.prior_valid = 1'b1;
          if (!hit) begin
            plain = 1'b1;
          end else begin
            burst_o.cp[n[1:0]] = c32[kps_pkg::OutBits-1:0];
            n = n + 3'd1;
            state_o.prior_fc = c_fc;
          end
        end else begin
          if (batchim) begin
            burst_o.cp[n[1:0]] = kps_pkg::OutBits'(kps_pkg::MarkerWith0[hit_idx]);
            n = n + 3'd1;
            if (kps_pkg::MarkerWith1[hit_idx] != 16'd0) begin
              burst_o.cp[n[1:0]] = kps_pkg::OutBits'(kps_pkg::MarkerWith1[hit_idx]);
              n = n + 3'd1;
            end
          end else begin
            burst_o.cp[n[1:0]] = kps_pkg::OutBits'(kps_pkg::MarkerNo0[hit_idx]);
            n = n + 3'd1;
          end
          state_o.prior_fc    = c_fc;
          state_o.prior_valid = 1'b1;
        end
      end
    endcase

    if (plain) begin
      if (c_narrow && c16 == kps_pkg::OpenParen) begin
        state_o.count = 2'd1;
      end else begin
        burst_o.cp[n[1:0]] = c32[kps_pkg::OutBits-1:0];
        n = n + 3'd1;
        state_o.prior_fc    = c_fc;
        state_o.prior_valid = 1'b1;
      end
    end

    // flush whatever is still held back, forget the previous character
    if (eot_i) begin
      held = state_o.count;
      if (held != 2'd0) begin
        burst_o.cp[n[1:0]] = kps_pkg::OutBits'(kps_pkg::OpenParen);
        n = n + 3'd1;
      end
      if (held >= 2'd2) begin
        burst_o.cp[n[1:0]] = kps_pkg::OutBits'(state_o.inner);
        n = n + 3'd1;
      end
      if (held == 2'd3) begin
        burst_o.cp[n[1:0]] = kps_pkg::OutBits'(kps_pkg::CloseParen);
        n = n + 3'd1;
      end
      state_o.count       = 2'd0;
      state_o.prior_fc    = 5'd0;
      state_o.prior_valid = 1'b0;
    end

    burst_o.count = n;
  end

endmodule

/* hw/rtl/korean_particle_selector.sv */
// Top level of the particle selector: input register, state, result shifter.
// Depends on kps_pkg and kps_rewrite.
`timescale 1ns / 1ps

// Rewrites a code-point stream, replacing each "(X)Y" particle marker with
// the form that fits the preceding character. One input transaction is taken
// per cycle while each code point yields at most one output and the output is
// not stalled; a code point that yields k outputs (up to four) occupies the
// four-entry result shifter until all k are taken, and a held-back marker
// character yields none. tlast on the input marks the end of
// text; tlast on the output marks the final code point produced by one input.

module korean_particle_selector #(
  parameter int CpBits = kps_pkg::CodePointBits,
  localparam int InDataBits = ((CpBits + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [InDataBits-1:0]              s_axis_tdata_i,  // code_point
  input  logic                               s_axis_tlast_i,  // end_of_text
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [kps_pkg::OutDataBits-1:0]    m_axis_tdata_o,  // out_code_point
  output logic                               m_axis_tlast_o   // last_of_run
);

  logic                                in_vld_q;
  logic [CpBits-1:0]                   in_cp_q;
  logic                                in_eot_q;
  kps_pkg::kps_state_t                 st_q;
  kps_pkg::kps_state_t                 st_d;
  kps_pkg::kps_burst_t                 burst_d;
  logic [2:0]                          cnt_q;
  logic [kps_pkg::MaxResults-1:0][kps_pkg::OutBits-1:0] res_q;
  logic                                res_free;
  logic                                move;
  logic                                take;

  assign take     = m_axis_tvalid_o && m_axis_tready_i;
  assign res_free = (cnt_q == 3'd0) || (cnt_q == 3'd1 && m_axis_tready_i);
  assign move     = in_vld_q && res_free;

  assign s_axis_tready_o = !in_vld_q || move;
  assign m_axis_tvalid_o = (cnt_q != 3'd0);
  assign m_axis_tlast_o  = (cnt_q == 3'd1);
  assign m_axis_tdata_o  = kps_pkg::OutDataBits'(res_q[0]);

  kps_rewrite #(
    .CpBits(CpBits)
  ) u_rewrite (
    .cp_i   (in_cp_q),
    .eot_i  (in_eot_q),
    .state_i(st_q),
    .state_o(st_d),
    .burst_o(burst_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      cnt_q    <= 3'd0;
      st_q     <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (move) begin
        st_q  <= st_d;
        cnt_q <= burst_d.count;
      end else if (take) begin
        cnt_q <= cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_cp_q  <= s_axis_tdata_i[CpBits-1:0];
      in_eot_q <= s_axis_tlast_i;
    end
    if (move) begin
      res_q <= burst_d.cp;
    end else if (take) begin
      for (int i = 0; i < kps_pkg::MaxResults - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(kps_pkg::MaxResults))
    else $error("result count beyond shifter depth");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !res_free |=> in_vld_q && $stable(in_cp_q) && $stable(in_eot_q))
    else $error("held input transaction lost or changed");

  a_eot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && in_eot_q |=> st_q.count == 2'd0 && !st_q.prior_valid)
    else $error("end of text left state behind");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !move |=> $stable(st_q))
    else $error("state changed without a transaction");

endmodule

/* tb/korean_particle_selector_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for korean_particle_selector: streams of code points with
// particle markers go in, the rewritten stream is checked against an in-bench predictor.
// Depends on kps_pkg and the RTL of the block; reads no files.

module korean_particle_selector_test;

  localparam int CpBits      = kps_pkg::CodePointBits;
  localparam int InBits      = ((CpBits + 7) / 8) * 8;
  localparam int OutBits     = kps_pkg::OutDataBits;
  localparam int ResultCap   = 4;
  localparam int MarkerKinds = 8;
  localparam int RandomItems = 360;
  localparam int SettleWait  = 20;
  localparam int CycleLimit  = 400000;

  localparam logic [CpBits-1:0] ParenOpen  = 21'h000028;
  localparam logic [CpBits-1:0] ParenClose = 21'h000029;
  localparam logic [CpBits-1:0] SylFirst   = 21'h00AC00;
  localparam logic [CpBits-1:0] SylLast    = 21'h00D7A3;
  localparam logic [CpBits-1:0] CpTop      = 21'h10FFFF;
  localparam int unsigned       JongCount  = 28;
  localparam int unsigned       RieulJong  = 8;

  typedef struct packed {
    logic [CpBits-1:0] inner;
    logic [CpBits-1:0] tail;
    logic [CpBits-1:0] batchim0;
    logic [CpBits-1:0] batchim1;
    logic [CpBits-1:0] plain;
    logic              eul_ro;
  } marker_rule_t;

  typedef struct packed {
    logic [CpBits-1:0] cp;
    logic              last;
  } out_char_t;

  typedef struct {
    logic [CpBits-1:0] cp;
    logic              eot;
    int unsigned       gap;
    bit                drain;
  } src_char_t;

  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_valid = 1'b0;
  logic               s_ready;
  logic [InBits-1:0]  s_data = '0;
  logic               s_last = 1'b0;
  logic               m_valid;
  logic               m_ready = 1'b0;
  logic [OutBits-1:0] m_data;
  logic               m_last;

  korean_particle_selector dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  src_char_t         source_text[$];
  out_char_t         expected_cps[$];
  src_char_t         next_src;
  int unsigned       gap_left = 0;
  int unsigned       rx_stall = 0;
  bit                rx_idle = 1'b0;
  bit                tx_idle = 1'b0;
  bit                drain_next = 1'b0;
  int unsigned       mismatches = 0;
  int unsigned       cycle_n = 0;

  // predictor state
  logic [CpBits-1:0] held [3];
  int unsigned       held_n = 0;
  logic [CpBits-1:0] prev_cp = '0;
  bit                prev_ok = 1'b0;
  logic [CpBits-1:0] step_cps[$];

  function automatic marker_rule_t marker_rule(input int idx);
    marker_rule_t r;
    case (idx)
      0:       r = '{21'hC774, 21'hAC00, 21'hC774, 21'h0,     21'hAC00, 1'b0};
      1:       r = '{21'hC640, 21'hACFC, 21'hACFC, 21'h0,     21'hC640, 1'b0};
      2:       r = '{21'hC744, 21'hB97C, 21'hC744, 21'h0,     21'hB97C, 1'b0};
      3:       r = '{21'hC740, 21'hB294, 21'hC740, 21'h0,     21'hB294, 1'b0};
      4:       r = '{21'hC544, 21'hC57C, 21'hC544, 21'h0,     21'hC57C, 1'b0};
      5:       r = '{21'hC73C, 21'hB85C, 21'hC73C, 21'hB85C,  21'hB85C, 1'b1};
      6:       r = '{21'hC774, 21'hC5EC, 21'hC774, 21'hC5EC,  21'hC5EC, 1'b0};
      default: r = '{21'hC774, 21'hB77C, 21'hC774, 21'hB77C,  21'hB77C, 1'b0};
    endcase
    return r;
  endfunction

  function automatic void put_char(input logic [CpBits-1:0] c);
    if (step_cps.size() < ResultCap) step_cps.push_back(c);
  endfunction

  function automatic void flush_held();
    int unsigned i;
    for (i = 0; i < held_n; i++) begin
      put_char(held[i]);
      prev_cp = held[i];
      prev_ok = 1'b1;
    end
    held_n = 0;
  endfunction

  function automatic void take_plain(input logic [CpBits-1:0] c);
    if (c == ParenOpen) begin
      held[0] = c;
      held_n  = 1;
    end else begin
      put_char(c);
      prev_cp = c;
      prev_ok = 1'b1;
    end
  endfunction

  function automatic bit is_inner(input logic [CpBits-1:0] c);
    marker_rule_t r;
    int i;
    for (i = 0; i < MarkerKinds; i++) begin
      r = marker_rule(i);
      if (r.inner == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit takes_batchim(input marker_rule_t r);
    int unsigned jong;
    if (prev_cp < SylFirst || prev_cp > SylLast) return 1'b0;
    jong = 32'(prev_cp - SylFirst) % JongCount;
    if (jong == 0) return 1'b0;
    if (r.eul_ro && jong == RieulJong) return 1'b0;
    return 1'b1;
  endfunction

  // work out the code points that one source transaction releases
  function automatic void rewrite_particles(input logic [CpBits-1:0] c, input logic eot);
    marker_rule_t r;
    marker_rule_t hit_rule;
    out_char_t    oc;
    bit           hit;
    int           i;
    step_cps.delete();
    hit      = 1'b0;
    hit_rule = '0;
    case (held_n)
      0: take_plain(c);
      1: begin
        if (is_inner(c)) begin
          held[1] = c;
          held_n  = 2;
        end else begin
          flush_held();
          take_plain(c);
        end
      end
      2: begin
        if (c == ParenClose) begin
          held[2] = c;
          held_n  = 3;
        end else begin
          flush_held();
          take_plain(c);
        end
      end
      default: begin
        for (i = 0; i < MarkerKinds; i++) begin
          r = marker_rule(i);
          if (r.inner == held[1] && r.tail == c) begin
            hit_rule = r;
            hit      = 1'b1;
          end
        end
        if (!hit) begin
          flush_held();
          take_plain(c);
        end else if (!prev_ok) begin
          flush_held();
          put_char(c);
          prev_cp = c;
          prev_ok = 1'b1;
        end else begin
          if (takes_batchim(hit_rule)) begin
            put_char(hit_rule.batchim0);
            if (hit_rule.batchim1 != '0) put_char(hit_rule.batchim1);
          end else begin
            put_char(hit_rule.plain);
          end
          held_n  = 0;
          prev_cp = c;
          prev_ok = 1'b1;
        end
      end
    endcase
    if (eot) begin
      flush_held();
      prev_cp = '0;
      prev_ok = 1'b0;
    end
    for (i = 0; i < step_cps.size(); i++) begin
      oc.cp   = step_cps[i];
      oc.last = (i == step_cps.size() - 1);
      expected_cps.push_back(oc);
    end
  endfunction

  function automatic logic [CpBits-1:0] rand_char();
    marker_rule_t r;
    r = marker_rule($urandom_range(0, MarkerKinds - 1));
    case ($urandom_range(0, 6))
      0: return CpBits'($urandom_range(0, 32'(CpTop)));
      1: return CpBits'(SylFirst + $urandom_range(0, 11171));
      2: return CpBits'(SylFirst + JongCount * $urandom_range(0, 398) + RieulJong);
      3: return CpBits'(SylFirst + JongCount * $urandom_range(0, 398));
      4: return CpBits'($urandom_range(32, 126));
      5: begin
        case ($urandom_range(0, 5))
          0:       return SylFirst - 1'b1;
          1:       return SylLast + 1'b1;
          2:       return SylFirst;
          3:       return SylLast;
          4:       return '0;
          default: return CpTop;
        endcase
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       return ParenOpen;
          1:       return ParenClose;
          2:       return r.inner;
          default: return r.tail;
        endcase
      end
    endcase
  endfunction

  task automatic add_char(input logic [CpBits-1:0] c, input bit eot);
    src_char_t it;
    it.cp      = c;
    it.eot     = eot;
    it.gap     = tx_idle ? $urandom_range(0, 16) : 0;
    it.drain   = drain_next;
    drain_next = 1'b0;
    source_text.push_back(it);
  endtask

  // first n characters of a marker, end of text on the last one if asked
  task automatic add_marker(input int idx, input int n, input bit eot);
    marker_rule_t r;
    logic [CpBits-1:0] seq [4];
    int i;
    r      = marker_rule(idx);
    seq[0] = ParenOpen;
    seq[1] = r.inner;
    seq[2] = ParenClose;
    seq[3] = r.tail;
    for (i = 0; i < n; i++) add_char(seq[i], eot && (i == n - 1));
  endtask

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CycleLimit) begin
      $display("korean_particle_selector_test failed");
      $finish;
    end
  end

  // source side: present queued code points, idle between them, hold for a drain
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid  <= 1'b0;
      s_data   <= '0;
      s_last   <= 1'b0;
      gap_left <= 0;
    end else begin
      if (s_valid && s_ready) rewrite_particles(s_data[CpBits-1:0], s_last);
      if (!s_valid || s_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_valid  <= 1'b0;
        end else if (source_text.size() != 0 &&
                     !(source_text[0].drain && expected_cps.size() != 0)) begin
          next_src = source_text.pop_front();
          s_valid  <= 1'b1;
          s_data   <= InBits'(next_src.cp);
          s_last   <= next_src.eot;
          gap_left <= next_src.gap;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // result side: check each transaction, and in idle phases stall for a drawn number of cycles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready  <= 1'b0;
      rx_stall <= 0;
    end else if (m_valid && m_ready) begin
      if (expected_cps.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual cp %h last %b",
                 $time, m_data, m_last);
        mismatches <= mismatches + 1;
      end else begin
        if (m_data !== OutBits'(expected_cps[0].cp) || m_last !== expected_cps[0].last) begin
          $display("%0t: expected cp %h last %b, actual cp %h last %b", $time,
                   OutBits'(expected_cps[0].cp), expected_cps[0].last, m_data, m_last);
          mismatches <= mismatches + 1;
        end
        void'(expected_cps.pop_front());
      end
      if ($urandom_range(0, 39) == 0) rx_idle = !rx_idle;
      if (rx_idle) begin
        rx_stall <= $urandom_range(0, 16);
        m_ready  <= 1'b0;
      end else begin
        rx_stall <= 0;
        m_ready  <= 1'b1;
      end
    end else if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
      m_ready  <= (rx_stall == 1);
    end else begin
      m_ready <= 1'b1;
    end
  end

  initial begin
    int pick;
    // marker at start of text passes through
    add_marker(0, 4, 1'b0);
    add_char(CpTop, 1'b0);
    add_marker(3, 4, 1'b0);
    // final rieul before the ro marker
    add_char(CpBits'(SylFirst + RieulJong), 1'b0);
    add_marker(5, 4, 1'b0);
    add_char(SylLast, 1'b0);
    add_marker(6, 4, 1'b0);
    // broken partial markers, then flush on end of text
    add_char(ParenOpen, 1'b0);
    add_char('0, 1'b0);
    add_marker(0, 3, 1'b0);
    add_char(ParenOpen, 1'b1);

    drain_next = 1'b1;
    while (source_text.size() < 25 + RandomItems) begin
      if ($urandom_range(0, 29) == 0) tx_idle = !tx_idle;
      if ($urandom_range(0, 79) == 0) drain_next = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        if ($urandom_range(0, 5) != 0) add_char(rand_char(), 1'b0);
        add_marker($urandom_range(0, MarkerKinds - 1), 4, $urandom_range(0, 7) == 0);
      end else if (pick < 8) begin
        add_marker($urandom_range(0, MarkerKinds - 1), $urandom_range(1, 3), 1'b0);
        add_char(rand_char(), $urandom_range(0, 5) == 0);
      end else begin
        add_char(rand_char(), $urandom_range(0, 7) == 0);
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (source_text.size() != 0 || s_valid) @(posedge clk_i);
    while (expected_cps.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("korean_particle_selector_test passed");
    end else begin
      $display("korean_particle_selector_test failed");
    end
    $finish;
  end

endmodule
